// ===== rtl/core/dbs_pkg.sv =====
// ----------------------------------------------------------------------------
// Depth background subtractor package
// Shared types, register indexes and default values for the subtractor core.
// ----------------------------------------------------------------------------
package dbs_pkg;

   localparam int MAX_PIXELS_DEFAULT         = 524288;
   localparam int RATE_FRACTION_BITS_DEFAULT = 16;

   localparam int DEPTH_W    = 16;
   localparam int RATE_W     = 17;
   localparam int FRAME_W    = 20;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 20;

   localparam logic [DEPTH_W-1:0] NO_VALUE  = 16'hFFFF;
   localparam logic [DEPTH_W-1:0] COUNT_MAX = 16'hFFFF;

   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE        = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_AVERAGE_RATE  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TOLERANCE     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_NO_DATA_EN    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_NO_DATA_THR   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_PIXELS  = 3'd5;

   localparam logic [RATE_W-1:0]  RESET_AVERAGE_RATE = 17'd6554;
   localparam logic [DEPTH_W-1:0] RESET_TOLERANCE    = 16'd0;
   localparam logic [DEPTH_W-1:0] RESET_NO_DATA_THR  = 16'd10;
   localparam logic [FRAME_W-1:0] RESET_FRAME_PIXELS = 20'd307200;

   typedef struct packed {
      logic               enable;
      logic [RATE_W-1:0]  average_rate;
      logic [DEPTH_W-1:0] tolerance;
      logic               no_data_reset_enable;
      logic [DEPTH_W-1:0] no_data_threshold;
      logic [FRAME_W-1:0] frame_pixels;
   } cfg_type;

   typedef struct packed {
      logic               valid;
      logic               process;
      logic               capture;
      logic               last;
      logic [DEPTH_W-1:0] depth;
   } item_type;

   typedef struct packed {
      logic               valid;
      logic [DEPTH_W-1:0] foreground_depth;
      logic               subtracted;
      logic               frame_end;
   } result_type;

   typedef enum logic {
      SEQ_CLEAR,
      SEQ_RUN
   } seq_state_type;

endpackage

// ===== rtl/core/dbs_channels.sv =====
// ----------------------------------------------------------------------------
// Depth background subtractor channels
// Valid/ready stream interfaces for the pixel input and the result output.
// ----------------------------------------------------------------------------
interface dbs_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] depth;
   logic        capture_background;

   modport source (output valid, output depth, output capture_background, input ready);
   modport sink (input valid, input depth, input capture_background, output ready);
endinterface

interface dbs_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] foreground_depth;
   logic        subtracted;
   logic        frame_end;

   modport source (output valid, output foreground_depth, output subtracted,
                   output frame_end, input ready);
   modport sink (input valid, input foreground_depth, input subtracted,
                 input frame_end, output ready);
endinterface

// ===== rtl/core/dbs_csr.sv =====
// ----------------------------------------------------------------------------
// Depth background subtractor configuration registers
// Write-only register file decoded from the plain write port.
// ----------------------------------------------------------------------------
module dbs_csr import dbs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ENABLE:       cfg_in.enable               = csr_wdata[0];
            CSR_AVERAGE_RATE: cfg_in.average_rate         = csr_wdata[RATE_W-1:0];
            CSR_TOLERANCE:    cfg_in.tolerance            = csr_wdata[DEPTH_W-1:0];
            CSR_NO_DATA_EN:   cfg_in.no_data_reset_enable = csr_wdata[0];
            CSR_NO_DATA_THR:  cfg_in.no_data_threshold    = csr_wdata[DEPTH_W-1:0];
            CSR_FRAME_PIXELS: cfg_in.frame_pixels         = csr_wdata[FRAME_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable               <= 1'b1;
         cfg_ff.average_rate         <= RESET_AVERAGE_RATE;
         cfg_ff.tolerance            <= RESET_TOLERANCE;
         cfg_ff.no_data_reset_enable <= 1'b1;
         cfg_ff.no_data_threshold    <= RESET_NO_DATA_THR;
         cfg_ff.frame_pixels         <= RESET_FRAME_PIXELS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/core/dbs_sequencer.sv =====
// ----------------------------------------------------------------------------
// Depth background subtractor sequencer
// Clearing pass after reset, pixel position, frame capture tracking and
// input admission with same-pixel hazard checking.
// ----------------------------------------------------------------------------
module dbs_sequencer import dbs_pkg::*; #(
   parameter int MAX_PIXELS = MAX_PIXELS_DEFAULT,
   localparam int ADDR_W = $clog2(MAX_PIXELS)
) (
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  logic               en,
   input  logic               req_valid,
   input  logic [DEPTH_W-1:0] req_depth,
   input  logic               req_capture,
   output logic               req_ready,
   input  logic               s1_valid,
   input  logic [ADDR_W-1:0]  s1_addr,
   input  logic               s2_valid,
   input  logic [ADDR_W-1:0]  s2_addr,
   output item_type           s0_item,
   output logic [ADDR_W-1:0]  s0_addr,
   output logic               clearing,
   output logic [ADDR_W-1:0]  clear_addr
);

   localparam int SW = (ADDR_W + 1 > FRAME_W) ? ADDR_W + 1 : FRAME_W;
   localparam logic [SW-1:0]     SIZE_MAX  = SW'(MAX_PIXELS);
   localparam logic [ADDR_W-1:0] CLEAR_END = ADDR_W'(MAX_PIXELS - 1);

   seq_state_type     state_ff;
   seq_state_type     state_in;
   logic [ADDR_W-1:0] clear_cnt_ff;
   logic [ADDR_W-1:0] clear_cnt_in;
   logic [ADDR_W-1:0] pos_ff;
   logic [ADDR_W-1:0] pos_in;
   logic              bg_valid_ff;
   logic              bg_valid_in;
   logic              all_cap_ff;
   logic              all_cap_in;

   logic              running;
   logic              hazard;
   logic              accept;
   logic              last;
   logic              all_cap_next;
   logic [SW-1:0]     fp_ext;
   logic [SW-1:0]     size;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         SEQ_CLEAR: begin
            if (clear_cnt_ff == CLEAR_END) begin
               state_in = SEQ_RUN;
            end
         end
         SEQ_RUN: state_in = SEQ_RUN;
         default: state_in = SEQ_CLEAR;
      endcase
   end

   always_comb begin
      running  = 1'b0;
      clearing = 1'b0;
      unique case (state_ff)
         SEQ_CLEAR: clearing = 1'b1;
         SEQ_RUN:   running  = 1'b1;
         default:   clearing = 1'b1;
      endcase
   end

   assign clear_addr   = clear_cnt_ff;
   assign clear_cnt_in = clearing ? clear_cnt_ff + ADDR_W'(1) : clear_cnt_ff;

   assign fp_ext = SW'(cfg.frame_pixels);
   always_comb begin
      if (fp_ext == '0) begin
         size = SW'(1);
      end else if (fp_ext > SIZE_MAX) begin
         size = SIZE_MAX;
      end else begin
         size = fp_ext;
      end
   end

   assign last   = (SW'(pos_ff) + SW'(1)) >= size;
   assign hazard = (s1_valid && (s1_addr == pos_ff)) || (s2_valid && (s2_addr == pos_ff));

   assign req_ready = running && en && !hazard;
   assign accept    = req_valid && req_ready;

   assign all_cap_next = all_cap_ff && cfg.enable && req_capture;

   always_comb begin
      pos_in      = pos_ff;
      bg_valid_in = bg_valid_ff;
      all_cap_in  = all_cap_ff;
      if (accept) begin
         if (last) begin
            pos_in      = '0;
            bg_valid_in = bg_valid_ff || all_cap_next;
            all_cap_in  = 1'b1;
         end else begin
            pos_in     = pos_ff + ADDR_W'(1);
            all_cap_in = all_cap_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_CLEAR;
         clear_cnt_ff <= '0;
         pos_ff       <= '0;
         bg_valid_ff  <= 1'b0;
         all_cap_ff   <= 1'b1;
      end else begin
         state_ff     <= state_in;
         clear_cnt_ff <= clear_cnt_in;
         pos_ff       <= pos_in;
         bg_valid_ff  <= bg_valid_in;
         all_cap_ff   <= all_cap_in;
      end
   end

   assign s0_addr         = pos_ff;
   assign s0_item.valid   = accept;
   assign s0_item.process = cfg.enable && (bg_valid_ff || req_capture);
   assign s0_item.capture = req_capture;
   assign s0_item.last    = last;
   assign s0_item.depth   = req_depth;

endmodule

// ===== rtl/core/dbs_pixel_store.sv =====
// ----------------------------------------------------------------------------
// Depth background subtractor pixel store
// Per-pixel average and zero-run memory plus background memory, each with
// one write port and one registered read port.
// ----------------------------------------------------------------------------
module dbs_pixel_store import dbs_pkg::*; #(
   parameter int MAX_PIXELS = MAX_PIXELS_DEFAULT,
   localparam int ADDR_W = $clog2(MAX_PIXELS)
) (
   input  logic                 clock,
   input  logic                 clearing,
   input  logic [ADDR_W-1:0]    clear_addr,
   input  logic                 rd_en,
   input  logic [ADDR_W-1:0]    rd_addr,
   input  logic                 st_wr_en,
   input  logic [ADDR_W-1:0]    wr_addr,
   input  logic [2*DEPTH_W-1:0] st_wr_data,
   input  logic                 bg_wr_en,
   input  logic [DEPTH_W-1:0]   bg_wr_data,
   output logic [DEPTH_W-1:0]   rd_avg,
   output logic [DEPTH_W-1:0]   rd_zero,
   output logic [DEPTH_W-1:0]   rd_bg
);

   logic [2*DEPTH_W-1:0] state_ram_ff [MAX_PIXELS];
   logic [DEPTH_W-1:0]   bg_ram_ff [MAX_PIXELS];
   logic [2*DEPTH_W-1:0] state_q_ff;
   logic [DEPTH_W-1:0]   bg_q_ff;

   logic                 sw_en;
   logic [ADDR_W-1:0]    sw_addr;
   logic [2*DEPTH_W-1:0] sw_data;

   // The clearing pass owns the state write port; the pipeline is empty then.
   assign sw_en   = clearing || st_wr_en;
   assign sw_addr = clearing ? clear_addr : wr_addr;
   assign sw_data = clearing ? {{DEPTH_W{1'b0}}, NO_VALUE} : st_wr_data;

   always_ff @(posedge clock) begin
      if (sw_en) begin
         state_ram_ff[sw_addr] <= sw_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         state_q_ff <= state_ram_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (bg_wr_en) begin
         bg_ram_ff[wr_addr] <= bg_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         bg_q_ff <= bg_ram_ff[rd_addr];
      end
   end

   assign rd_avg  = state_q_ff[DEPTH_W-1:0];
   assign rd_zero = state_q_ff[2*DEPTH_W-1:DEPTH_W];
   assign rd_bg   = bg_q_ff;

endmodule

// ===== rtl/core/dbs_update.sv =====
// ----------------------------------------------------------------------------
// Depth background subtractor update pipeline
// Zero-run and blend products, average write-back with background capture,
// and the foreground decision, over three register stages.
// ----------------------------------------------------------------------------
module dbs_update import dbs_pkg::*; #(
   parameter int MAX_PIXELS         = MAX_PIXELS_DEFAULT,
   parameter int RATE_FRACTION_BITS = RATE_FRACTION_BITS_DEFAULT,
   localparam int ADDR_W = $clog2(MAX_PIXELS)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  cfg_type              cfg,
   input  item_type             s0_item,
   input  logic [ADDR_W-1:0]    s0_addr,
   input  logic [DEPTH_W-1:0]   rd_avg,
   input  logic [DEPTH_W-1:0]   rd_zero,
   input  logic [DEPTH_W-1:0]   rd_bg,
   output logic                 st_wr_en,
   output logic [ADDR_W-1:0]    wr_addr,
   output logic [2*DEPTH_W-1:0] st_wr_data,
   output logic                 bg_wr_en,
   output logic [DEPTH_W-1:0]   bg_wr_data,
   output logic                 s1_valid,
   output logic [ADDR_W-1:0]    s1_addr,
   output logic                 s2_valid,
   output logic [ADDR_W-1:0]    s2_addr,
   output result_type           result
);

   localparam int AW   = RATE_FRACTION_BITS + 1;
   localparam int CW   = (AW > RATE_W) ? AW : RATE_W;
   localparam int PW   = DEPTH_W + AW;
   localparam int SUMW = PW + 1;
   localparam logic [CW-1:0] ONE_CW = CW'(1) << RATE_FRACTION_BITS;

   item_type           s1_item_ff;
   logic [ADDR_W-1:0]  s1_addr_ff;

   item_type           s2_item_ff;
   logic [ADDR_W-1:0]  s2_addr_ff;
   logic [PW-1:0]      prod_keep_ff;
   logic [PW-1:0]      prod_new_ff;
   logic [DEPTH_W-1:0] avg_pre_ff;
   logic               blend_ff;
   logic [DEPTH_W-1:0] zero_ff;
   logic [DEPTH_W-1:0] bg_old_ff;

   item_type           s3_item_ff;
   logic [DEPTH_W-1:0] s3_bg_ff;

   logic [CW-1:0]      rate_ext;
   logic [AW-1:0]      a_eff;
   logic [AW-1:0]      keep_w;
   logic [PW-1:0]      prod_keep_in;
   logic [PW-1:0]      prod_new_in;
   logic [DEPTH_W-1:0] avg_pre_in;
   logic               blend_in;
   logic [DEPTH_W-1:0] zero_in;
   logic [DEPTH_W-1:0] count_up;

   logic [SUMW-1:0]    sum;
   logic [DEPTH_W-1:0] avg_new;
   logic [DEPTH_W-1:0] bg_new;
   logic [DEPTH_W-1:0] s3_bg_in;

   logic [DEPTH_W:0]   limit;
   logic               keep;

   assign rate_ext = CW'(cfg.average_rate);
   assign a_eff    = (rate_ext > ONE_CW) ? AW'(ONE_CW) : AW'(rate_ext);
   assign keep_w   = AW'(ONE_CW) - a_eff;

   // Stage 1: memory data has arrived; form the blend products and zero run.
   assign count_up = (rd_zero == COUNT_MAX) ? COUNT_MAX : rd_zero + DEPTH_W'(1);

   always_comb begin
      zero_in    = rd_zero;
      avg_pre_in = rd_avg;
      blend_in   = 1'b0;
      if (!s1_item_ff.process) begin
         zero_in = '0;
      end else if (s1_item_ff.depth != '0) begin
         zero_in    = '0;
         avg_pre_in = s1_item_ff.depth;
         blend_in   = (rd_avg != NO_VALUE);
      end else if (cfg.no_data_reset_enable) begin
         zero_in = count_up;
         if (count_up >= cfg.no_data_threshold) begin
            avg_pre_in = NO_VALUE;
         end
      end
   end

   assign prod_keep_in = PW'(rd_avg) * PW'(keep_w);
   assign prod_new_in  = PW'(s1_item_ff.depth) * PW'(a_eff);

   // Stage 2: finish the average, write it back and capture the background.
   assign sum     = SUMW'(prod_keep_ff) + SUMW'(prod_new_ff);
   assign avg_new = blend_ff ? sum[RATE_FRACTION_BITS +: DEPTH_W] : avg_pre_ff;
   assign bg_new  = (avg_new == '0) ? NO_VALUE : avg_new;

   assign st_wr_en   = en && s2_item_ff.valid;
   assign wr_addr    = s2_addr_ff;
   assign st_wr_data = {zero_ff, avg_new};
   assign bg_wr_en   = en && s2_item_ff.valid && s2_item_ff.process && s2_item_ff.capture;
   assign bg_wr_data = bg_new;
   assign s3_bg_in   = (s2_item_ff.process && s2_item_ff.capture) ? bg_new : bg_old_ff;

   // Stage 3: for a processed pixel, keep it only where background minus depth exceeds tolerance.
   assign limit = {1'b0, s3_item_ff.depth} + {1'b0, cfg.tolerance};
   assign keep  = {1'b0, s3_bg_ff} > limit;

   always_comb begin
      result.valid      = s3_item_ff.valid;
      result.frame_end  = s3_item_ff.last;
      if (!s3_item_ff.process || keep) begin
         result.foreground_depth = s3_item_ff.depth;
      end else begin
         result.foreground_depth = '0;
      end
      result.subtracted = (result.foreground_depth != s3_item_ff.depth);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_item_ff.valid <= 1'b0;
         s2_item_ff.valid <= 1'b0;
         s3_item_ff.valid <= 1'b0;
      end else if (en) begin
         s1_item_ff.valid <= s0_item.valid;
         s2_item_ff.valid <= s1_item_ff.valid;
         s3_item_ff.valid <= s2_item_ff.valid;
      end
      if (en) begin
         s1_item_ff.process <= s0_item.process;
         s1_item_ff.capture <= s0_item.capture;
         s1_item_ff.last    <= s0_item.last;
         s1_item_ff.depth   <= s0_item.depth;
         s1_addr_ff         <= s0_addr;

         s2_item_ff.process <= s1_item_ff.process;
         s2_item_ff.capture <= s1_item_ff.capture;
         s2_item_ff.last    <= s1_item_ff.last;
         s2_item_ff.depth   <= s1_item_ff.depth;
         s2_addr_ff         <= s1_addr_ff;
         prod_keep_ff       <= prod_keep_in;
         prod_new_ff        <= prod_new_in;
         avg_pre_ff         <= avg_pre_in;
         blend_ff           <= blend_in;
         zero_ff            <= zero_in;
         bg_old_ff          <= rd_bg;

         s3_item_ff.process <= s2_item_ff.process;
         s3_item_ff.capture <= s2_item_ff.capture;
         s3_item_ff.last    <= s2_item_ff.last;
         s3_item_ff.depth   <= s2_item_ff.depth;
         s3_bg_ff           <= s3_bg_in;
      end
   end

   assign s1_valid = s1_item_ff.valid;
   assign s1_addr  = s1_addr_ff;
   assign s2_valid = s2_item_ff.valid;
   assign s2_addr  = s2_addr_ff;

endmodule

// ===== rtl/core/depth_background_subtractor_core.sv =====
// ----------------------------------------------------------------------------
// Depth background subtractor core
// Running-average background model per pixel with foreground extraction.
// ----------------------------------------------------------------------------
// Depth pixels enter on req_chan in raster order with a capture flag; one
// result per pixel leaves on rsp_chan in the same order. Registers are written
// through csr_wr_en, csr_index and csr_wdata; the user must write them only
// while the block is idle, which the block itself does not enforce.
// rsp_chan.valid rises once an input transfer has passed the update pipeline
// stages and the output register. The block takes one pixel per cycle; the
// limit is the read-modify-write of the pixel memory, which spans two
// pipeline stages, so a pixel waits while an earlier item for the same
// position is still in flight. Frames of one or two pixels are therefore
// slowed by this wait.
// After reset the block sweeps the pixel memory, one entry per cycle, over
// all MAX_PIXELS entries, setting every average to no value and every zero
// count to zero; req_chan.ready stays low during the sweep. When the receiver
// stalls, the whole pipeline holds and req_chan.ready drops once the output
// register is full and not taken.
// ----------------------------------------------------------------------------
module depth_background_subtractor_core import dbs_pkg::*; #(
   parameter int MAX_PIXELS         = MAX_PIXELS_DEFAULT,
   parameter int RATE_FRACTION_BITS = RATE_FRACTION_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   dbs_req_if.sink               req_chan,
   dbs_rsp_if.source             rsp_chan,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int ADDR_W = $clog2(MAX_PIXELS);

   cfg_type              cfg;
   item_type             s0_item;
   logic [ADDR_W-1:0]    s0_addr;
   logic                 en;
   logic                 clearing;
   logic [ADDR_W-1:0]    clear_addr;
   logic                 s1_valid;
   logic [ADDR_W-1:0]    s1_addr;
   logic                 s2_valid;
   logic [ADDR_W-1:0]    s2_addr;
   logic                 st_wr_en;
   logic [ADDR_W-1:0]    wr_addr;
   logic [2*DEPTH_W-1:0] st_wr_data;
   logic                 bg_wr_en;
   logic [DEPTH_W-1:0]   bg_wr_data;
   logic [DEPTH_W-1:0]   rd_avg;
   logic [DEPTH_W-1:0]   rd_zero;
   logic [DEPTH_W-1:0]   rd_bg;
   result_type           result;

   logic                 rsp_valid_ff;
   logic [DEPTH_W-1:0]   rsp_fg_ff;
   logic                 rsp_sub_ff;
   logic                 rsp_end_ff;

   assign en = !rsp_valid_ff || rsp_chan.ready;

   dbs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   dbs_sequencer #(
      .MAX_PIXELS (MAX_PIXELS)
   ) u_sequencer (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .en          (en),
      .req_valid   (req_chan.valid),
      .req_depth   (req_chan.depth),
      .req_capture (req_chan.capture_background),
      .req_ready   (req_chan.ready),
      .s1_valid    (s1_valid),
      .s1_addr     (s1_addr),
      .s2_valid    (s2_valid),
      .s2_addr     (s2_addr),
      .s0_item     (s0_item),
      .s0_addr     (s0_addr),
      .clearing    (clearing),
      .clear_addr  (clear_addr)
   );

   dbs_pixel_store #(
      .MAX_PIXELS (MAX_PIXELS)
   ) u_store (
      .clock      (clock),
      .clearing   (clearing),
      .clear_addr (clear_addr),
      .rd_en      (en),
      .rd_addr    (s0_addr),
      .st_wr_en   (st_wr_en),
      .wr_addr    (wr_addr),
      .st_wr_data (st_wr_data),
      .bg_wr_en   (bg_wr_en),
      .bg_wr_data (bg_wr_data),
      .rd_avg     (rd_avg),
      .rd_zero    (rd_zero),
      .rd_bg      (rd_bg)
   );

   dbs_update #(
      .MAX_PIXELS         (MAX_PIXELS),
      .RATE_FRACTION_BITS (RATE_FRACTION_BITS)
   ) u_update (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .cfg        (cfg),
      .s0_item    (s0_item),
      .s0_addr    (s0_addr),
      .rd_avg     (rd_avg),
      .rd_zero    (rd_zero),
      .rd_bg      (rd_bg),
      .st_wr_en   (st_wr_en),
      .wr_addr    (wr_addr),
      .st_wr_data (st_wr_data),
      .bg_wr_en   (bg_wr_en),
      .bg_wr_data (bg_wr_data),
      .s1_valid   (s1_valid),
      .s1_addr    (s1_addr),
      .s2_valid   (s2_valid),
      .s2_addr    (s2_addr),
      .result     (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= result.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_fg_ff  <= result.foreground_depth;
         rsp_sub_ff <= result.subtracted;
         rsp_end_ff <= result.frame_end;
      end
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.foreground_depth = rsp_fg_ff;
   assign rsp_chan.subtracted       = rsp_sub_ff;
   assign rsp_chan.frame_end        = rsp_end_ff;

`ifndef SYNTH
   a_no_transfer_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !req_chan.ready)
      else $error("input transfer possible during the clearing pass");

   a_no_pixel_hazard: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |->
         !(s1_valid && (s1_addr == s0_addr)) && !(s2_valid && (s2_addr == s0_addr)))
      else $error("pixel admitted while an older item for it is in flight");

   a_no_write_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !st_wr_en && !bg_wr_en && !s1_valid && !s2_valid)
      else $error("pipeline write collides with the clearing pass");
`endif

endmodule
